// ===== sv/mpt_pkg.sv =====
// Shared types, prefix codes and helper functions for the MessagePack tokenizer.
package mpt_pkg;

	// Token kinds as they appear on the token_kind port.
	typedef enum logic [3:0] {
		TK_NIL   = 4'd0,
		TK_BOOL  = 4'd1,
		TK_INT   = 4'd2,
		TK_FLOAT = 4'd3,
		TK_STR   = 4'd4,
		TK_BIN   = 4'd5,
		TK_ARRAY = 4'd6,
		TK_MAP   = 4'd7,
		TK_BYTE  = 4'd8,
		TK_ERROR = 4'd9
	} tok_kind_t;

	// Decoder phase.
	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_OPER    = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	// Error codes.
	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_INVALID   = 2'd1;
	localparam logic [1:0] ERR_TRUNCATED = 2'd2;

	// Fixed-format range limits.
	localparam logic [7:0] FIXINT_POS_MAX = 8'h7F;
	localparam logic [7:0] FIXMAP_MAX     = 8'h8F;
	localparam logic [7:0] FIXARR_MAX     = 8'h9F;
	localparam logic [7:0] FIXSTR_MAX     = 8'hBF;
	localparam logic [7:0] FIXINT_NEG_MIN = 8'hE0;
	localparam logic [7:0] FIXCNT_MASK    = 8'h0F;
	localparam logic [7:0] FIXSTR_MASK    = 8'h1F;

	// Single-byte and operand-carrying prefixes.
	localparam logic [7:0] PFX_NIL    = 8'hC0;
	localparam logic [7:0] PFX_FALSE  = 8'hC2;
	localparam logic [7:0] PFX_TRUE   = 8'hC3;
	localparam logic [7:0] PFX_BIN8   = 8'hC4;
	localparam logic [7:0] PFX_BIN16  = 8'hC5;
	localparam logic [7:0] PFX_BIN32  = 8'hC6;
	localparam logic [7:0] PFX_F32    = 8'hCA;
	localparam logic [7:0] PFX_F64    = 8'hCB;
	localparam logic [7:0] PFX_U8     = 8'hCC;
	localparam logic [7:0] PFX_U16    = 8'hCD;
	localparam logic [7:0] PFX_U32    = 8'hCE;
	localparam logic [7:0] PFX_U64    = 8'hCF;
	localparam logic [7:0] PFX_I8     = 8'hD0;
	localparam logic [7:0] PFX_I16    = 8'hD1;
	localparam logic [7:0] PFX_I32    = 8'hD2;
	localparam logic [7:0] PFX_I64    = 8'hD3;
	localparam logic [7:0] PFX_STR8   = 8'hD9;
	localparam logic [7:0] PFX_STR16  = 8'hDA;
	localparam logic [7:0] PFX_STR32  = 8'hDB;
	localparam logic [7:0] PFX_ARR16  = 8'hDC;
	localparam logic [7:0] PFX_ARR32  = 8'hDD;
	localparam logic [7:0] PFX_MAP16  = 8'hDE;
	localparam logic [7:0] PFX_MAP32  = 8'hDF;

	// Number of big-endian operand bytes after a prefix; zero for a byte without operands.
	function automatic logic [3:0] opnd_count(input logic [7:0] b);
		logic [3:0] n;
		case (b) inside
			PFX_BIN8, PFX_U8, PFX_I8, PFX_STR8: n = 4'd1;
			PFX_BIN16, PFX_U16, PFX_I16, PFX_STR16, PFX_ARR16, PFX_MAP16: n = 4'd2;
			PFX_BIN32, PFX_F32, PFX_U32, PFX_I32, PFX_STR32, PFX_ARR32,
			PFX_MAP32: n = 4'd4;
			PFX_F64, PFX_U64, PFX_I64: n = 4'd8;
			default: n = 4'd0;
		endcase
		return n;
	endfunction

	// Token kind produced once the operands of a prefix are complete.
	function automatic tok_kind_t fin_kind(input logic [7:0] b);
		tok_kind_t k;
		case (b) inside
			PFX_F32, PFX_F64: k = TK_FLOAT;
			PFX_U8, PFX_U16, PFX_U32, PFX_U64,
			PFX_I8, PFX_I16, PFX_I32, PFX_I64: k = TK_INT;
			PFX_BIN8, PFX_BIN16, PFX_BIN32: k = TK_BIN;
			PFX_STR8, PFX_STR16, PFX_STR32: k = TK_STR;
			PFX_ARR16, PFX_ARR32: k = TK_ARRAY;
			default: k = TK_MAP;
		endcase
		return k;
	endfunction

	// Exact widening of a single-precision pattern to double precision.
	function automatic logic [63:0] widen_f32(input logic [31:0] f);
		logic [7:0]  ex;
		logic [22:0] man;
		logic [4:0]  msb;
		logic [45:0] shifted;
		logic [10:0] dex;
		logic [63:0] r;
		ex  = f[30:23];
		man = f[22:0];
		msb = 5'd0;
		// Position of the leading one in a subnormal mantissa.
		for (int i = 0; i < 23; i++) begin
			if (man[i]) begin
				msb = 5'(i);
			end
		end
		shifted = {23'd0, man} << (5'd23 - msb);
		if (ex == 8'hFF) begin
			r = {f[31], 11'h7FF, (man != 23'd0), man[21:0], 29'd0};
		end else if (ex == 8'h00) begin
			dex = 11'(msb) + 11'd874;
			if (man == 23'd0) begin
				r = {f[31], 63'd0};
			end else begin
				r = {f[31], dex, shifted[22:0], 29'd0};
			end
		end else begin
			dex = 11'(ex) + 11'd896;
			r = {f[31], dex, man, 29'd0};
		end
		return r;
	endfunction

endpackage

// ===== sv/msgpack_stream_tokenizer_core.sv =====
// Top level of the streaming MessagePack tokenizer: byte register, decoder and token register.
//
// The tokenizer takes one encoded byte per clock and gives at most one token per byte, so a
// stream runs at a sustained one byte per cycle while the token side does not stall. Each
// byte passes through an input register and then the decoder logic into the token register;
// the decoder state (phase, operand accumulator and payload count) is updated in the same
// cycle the token register loads, which is what allows the next byte to follow immediately.
// Bytes that only feed operands, and bytes discarded after an invalid prefix, produce no
// token. The byte side stalls only while a token is held in the token register and the token
// side is itself stalled.
module msgpack_stream_tokenizer_core (
	input  logic               clk,
	input  logic               arst_n,
	// Byte channel
	input  logic               byte_valid,
	output logic               byte_stall,
	input  logic [7:0]         data_byte,
	input  logic               end_of_buffer,
	// Token channel
	output logic               token_valid,
	input  logic               token_stall,
	output logic [3:0]         token_kind,
	output logic signed [63:0] token_value,
	output logic [7:0]         payload_byte,
	output logic               payload_last,
	output logic [1:0]         error_code
);
	import mpt_pkg::*;

	// Input register
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       eob_s1;

	// Token register
	logic        valid_s2;
	logic [3:0]  kind_s2;
	logic [63:0] value_s2;
	logic [7:0]  pbyte_s2;
	logic        last_s2;
	logic [1:0]  err_s2;

	// Decoder state
	phase_t      phase_q;
	logic [7:0]  prefix_q;
	logic [3:0]  opnd_left_q;
	logic [63:0] acc_q;
	logic [31:0] pay_left_q;
	logic        discard_q;

	// Next state and decoded token
	phase_t      phase_n;
	logic [7:0]  prefix_n;
	logic [3:0]  opnd_left_n;
	logic [63:0] acc_n;
	logic [31:0] pay_left_n;
	logic        discard_n;
	logic        emit;
	tok_kind_t   kind;
	logic [63:0] value;
	logic [7:0]  pbyte;
	logic        last;
	logic [1:0]  err;
	logic        do_hdr;
	tok_kind_t   hdr_kind;
	logic [31:0] hdr_len;
	logic [3:0]  n_opnd;
	logic [63:0] acc_shift;

	logic advance;

	// The token register can take a new beat when empty or when its beat leaves.
	assign advance    = !valid_s2 || !token_stall;
	assign byte_stall = valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			data_s1 <= data_byte;
			eob_s1  <= end_of_buffer;
		end
	end

	// Decoder: classify a prefix, gather operands, or pass payload through.
	always_comb begin
		phase_n     = phase_q;
		prefix_n    = prefix_q;
		opnd_left_n = opnd_left_q;
		acc_n       = acc_q;
		pay_left_n  = pay_left_q;
		discard_n   = discard_q;
		emit        = 1'b0;
		kind        = TK_NIL;
		value       = 64'd0;
		pbyte       = 8'd0;
		last        = 1'b0;
		err         = ERR_NONE;
		do_hdr      = 1'b0;
		hdr_kind    = TK_STR;
		hdr_len     = 32'd0;
		n_opnd      = opnd_count(data_s1);
		acc_shift   = {acc_q[55:0], data_s1};

		if (discard_q) begin
			// Skip everything up to and including the end-marked byte.
			if (eob_s1) begin
				discard_n   = 1'b0;
				phase_n     = PH_IDLE;
				prefix_n    = 8'd0;
				opnd_left_n = 4'd0;
				acc_n       = 64'd0;
				pay_left_n  = 32'd0;
			end
		end else begin
			case (phase_q)
				PH_OPER: begin
					acc_n       = acc_shift;
					opnd_left_n = opnd_left_q - 4'd1;
					if (opnd_left_n != 4'd0) begin
						if (eob_s1) begin
							emit = 1'b1;
							kind = TK_ERROR;
							err  = ERR_TRUNCATED;
						end
					end else begin
						kind = fin_kind(prefix_q);
						case (prefix_q)
							PFX_F32: value = widen_f32(acc_shift[31:0]);
							PFX_I8:  value = {{56{acc_shift[7]}}, acc_shift[7:0]};
							PFX_I16: value = {{48{acc_shift[15]}}, acc_shift[15:0]};
							PFX_I32: value = {{32{acc_shift[31]}}, acc_shift[31:0]};
							default: value = acc_shift;
						endcase
						if (kind == TK_STR || kind == TK_BIN) begin
							do_hdr   = 1'b1;
							hdr_kind = kind;
							hdr_len  = acc_shift[31:0];
						end else begin
							emit = 1'b1;
						end
					end
					if (!(opnd_left_n != 4'd0 && !eob_s1)) begin
						phase_n     = PH_IDLE;
						prefix_n    = 8'd0;
						opnd_left_n = 4'd0;
						acc_n       = 64'd0;
						pay_left_n  = 32'd0;
					end
				end
				PH_PAYLOAD: begin
					emit       = 1'b1;
					pay_left_n = pay_left_q - 32'd1;
					if (pay_left_n != 32'd0 && eob_s1) begin
						kind = TK_ERROR;
						err  = ERR_TRUNCATED;
					end else begin
						kind  = TK_BYTE;
						pbyte = data_s1;
						last  = (pay_left_n == 32'd0);
					end
					if (pay_left_n == 32'd0 || eob_s1) begin
						phase_n    = PH_IDLE;
						pay_left_n = 32'd0;
					end
				end
				default: begin
					// Idle: classify the prefix byte.
					phase_n     = PH_IDLE;
					prefix_n    = 8'd0;
					opnd_left_n = 4'd0;
					acc_n       = 64'd0;
					pay_left_n  = 32'd0;
					if (data_s1 <= FIXINT_POS_MAX || data_s1 >= FIXINT_NEG_MIN) begin
						emit  = 1'b1;
						kind  = TK_INT;
						value = {{56{data_s1[7]}}, data_s1};
					end else if (data_s1 <= FIXMAP_MAX) begin
						emit  = 1'b1;
						kind  = TK_MAP;
						value = {56'd0, data_s1 & FIXCNT_MASK};
					end else if (data_s1 <= FIXARR_MAX) begin
						emit  = 1'b1;
						kind  = TK_ARRAY;
						value = {56'd0, data_s1 & FIXCNT_MASK};
					end else if (data_s1 <= FIXSTR_MAX) begin
						do_hdr   = 1'b1;
						hdr_kind = TK_STR;
						hdr_len  = {24'd0, data_s1 & FIXSTR_MASK};
					end else if (data_s1 == PFX_NIL) begin
						emit = 1'b1;
						kind = TK_NIL;
					end else if (data_s1 == PFX_FALSE || data_s1 == PFX_TRUE) begin
						emit  = 1'b1;
						kind  = TK_BOOL;
						value = {63'd0, data_s1[0]};
					end else if (n_opnd == 4'd0) begin
						emit      = 1'b1;
						kind      = TK_ERROR;
						err       = ERR_INVALID;
						discard_n = !eob_s1;
					end else if (eob_s1) begin
						emit = 1'b1;
						kind = TK_ERROR;
						err  = ERR_TRUNCATED;
					end else begin
						phase_n     = PH_OPER;
						prefix_n    = data_s1;
						opnd_left_n = n_opnd;
					end
				end
			endcase

			// Str and bin headers: truncated if payload is due but the buffer ends.
			if (do_hdr) begin
				emit = 1'b1;
				if (hdr_len != 32'd0 && eob_s1) begin
					kind  = TK_ERROR;
					err   = ERR_TRUNCATED;
					value = 64'd0;
				end else begin
					kind  = hdr_kind;
					value = {32'd0, hdr_len};
					if (hdr_len != 32'd0) begin
						phase_n    = PH_PAYLOAD;
						pay_left_n = hdr_len;
					end
				end
			end
		end
	end

	// Decoder state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			prefix_q    <= 8'd0;
			opnd_left_q <= 4'd0;
			acc_q       <= 64'd0;
			pay_left_q  <= 32'd0;
			discard_q   <= 1'b0;
		end else if (valid_s1 && advance) begin
			phase_q     <= phase_n;
			prefix_q    <= prefix_n;
			opnd_left_q <= opnd_left_n;
			acc_q       <= acc_n;
			pay_left_q  <= pay_left_n;
			discard_q   <= discard_n;
		end
	end

	// Token register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			kind_s2  <= kind;
			value_s2 <= value;
			pbyte_s2 <= pbyte;
			last_s2  <= last;
			err_s2   <= err;
		end
	end

	assign token_valid  = valid_s2;
	assign token_kind   = kind_s2;
	assign token_value  = value_s2;
	assign payload_byte = pbyte_s2;
	assign payload_last = last_s2;
	assign error_code   = err_s2;

	// Discarding only ever happens from the idle phase.
	assert property (@(posedge clk) disable iff (!arst_n)
		discard_q |-> phase_q == PH_IDLE)
		else $error("discarding outside the idle phase");

	// Operand gathering always has at least one byte outstanding.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_OPER |-> opnd_left_q != 4'd0 && prefix_q != 8'd0)
		else $error("operand phase with nothing outstanding");

	// Payload pass-through always has at least one byte outstanding.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> pay_left_q != 32'd0)
		else $error("payload phase with zero count");

	// An error code appears only on error tokens, and every error token carries one.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((kind_s2 == TK_ERROR) == (err_s2 != ERR_NONE)))
		else $error("error code does not match token kind");
endmodule

// ===== tb/sv/tb_msgpack_stream_tokenizer_core.sv =====
// Self-checking testbench for the streaming MessagePack tokenizer core.
module tb_msgpack_stream_tokenizer_core;
	import mpt_pkg::*;

	localparam int RANDOM_ITEMS = 1420;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_STRING = 40;
	localparam logic [7:0] PFX_RESERVED = 8'hC1;

	// How a generated value closes its buffer.
	localparam int VAL_OPEN = 0;
	localparam int VAL_LONG = 1;
	localparam int VAL_BAD = 2;

	typedef struct {
		logic [7:0] data;
		logic       eob;
		logic       drain;
		int         idle_pct;
		int         stall_pct;
	} feed_item_t;

	typedef struct {
		tok_kind_t   kind;
		logic [63:0] value;
		logic [7:0]  pbyte;
		logic        plast;
		logic [1:0]  err;
	} token_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic byte_valid = 1'b0;
	logic byte_stall;
	logic [7:0] data_byte = 8'd0;
	logic end_of_buffer = 1'b0;
	logic token_valid;
	logic token_stall = 1'b0;
	logic [3:0] token_kind;
	logic signed [63:0] token_value;
	logic [7:0] payload_byte;
	logic payload_last;
	logic [1:0] error_code;

	feed_item_t feed_q[$];
	token_t tokens_due[$];
	logic [7:0] frame_q[$];
	logic byte_taken = 1'b0;
	int stall_pct = 0;
	int quiet_cycles = 0;
	int mismatches = 0;
	int rand_count = 0;
	int fill_idle = 0;
	int fill_stall = 0;
	logic drain_next = 1'b0;

	// Decoder state as the block should hold it.
	phase_t      dec_phase = PH_IDLE;
	logic [7:0]  dec_prefix = 8'd0;
	logic [3:0]  dec_opnd_left = 4'd0;
	logic [63:0] dec_acc = 64'd0;
	logic [31:0] dec_pay_left = 32'd0;
	logic        dec_discard = 1'b0;

	msgpack_stream_tokenizer_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.data_byte(data_byte),
		.end_of_buffer(end_of_buffer),
		.token_valid(token_valid),
		.token_stall(token_stall),
		.token_kind(token_kind),
		.token_value(token_value),
		.payload_byte(payload_byte),
		.payload_last(payload_last),
		.error_code(error_code)
	);

	always #1 clk = ~clk;

	// Number of big-endian operand bytes that follow a prefix.
	function automatic int operand_len(input logic [7:0] p);
		case (p)
			PFX_BIN8, PFX_U8, PFX_I8, PFX_STR8: return 1;
			PFX_BIN16, PFX_U16, PFX_I16, PFX_STR16, PFX_ARR16, PFX_MAP16: return 2;
			PFX_BIN32, PFX_F32, PFX_U32, PFX_I32, PFX_STR32, PFX_ARR32, PFX_MAP32: return 4;
			PFX_F64, PFX_U64, PFX_I64: return 8;
			default: return 0;
		endcase
	endfunction

	// True for prefixes in the reserved and ext range, which the block rejects.
	function automatic logic bad_prefix(input logic [7:0] p);
		return p > FIXSTR_MAX && p < FIXINT_NEG_MIN && p != PFX_NIL && p != PFX_FALSE
			&& p != PFX_TRUE && operand_len(p) == 0;
	endfunction

	function automatic logic is_string_prefix(input logic [7:0] p);
		case (p)
			PFX_BIN8, PFX_BIN16, PFX_BIN32, PFX_STR8, PFX_STR16, PFX_STR32: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// Exact single to double widening; subnormals are normalised, NaNs made quiet.
	function automatic logic [63:0] f32_to_f64(input logic [31:0] f);
		logic [23:0] m;
		logic [10:0] e;
		logic [51:0] frac;
		m = {1'b0, f[22:0]};
		if (f[30:23] == 8'hFF) begin
			frac = {f[22:0], 29'd0};
			if (f[22:0] != 23'd0) begin
				frac[51] = 1'b1;
			end
			return {f[31], 11'h7FF, frac};
		end
		if (f[30:23] == 8'h00) begin
			if (m == 24'd0) begin
				return {f[31], 63'd0};
			end
			e = 11'd897;
			while (!m[23]) begin
				m = m << 1;
				e = e - 11'd1;
			end
			return {f[31], e, m[22:0], 29'd0};
		end
		return {f[31], {3'd0, f[30:23]} + 11'd896, f[22:0], 29'd0};
	endfunction

	function automatic void clear_state();
		dec_phase = PH_IDLE;
		dec_prefix = 8'd0;
		dec_opnd_left = 4'd0;
		dec_acc = 64'd0;
		dec_pay_left = 32'd0;
	endfunction

	function automatic token_t truncated_token();
		token_t t;
		t = '{TK_ERROR, 64'd0, 8'd0, 1'b0, ERR_TRUNCATED};
		return t;
	endfunction

	// A str or bin header; a non-empty one that ends the buffer is truncated.
	function automatic void start_string(input tok_kind_t k, input logic [31:0] len,
			input logic eob, output token_t t);
		clear_state();
		t = '{k, {32'd0, len}, 8'd0, 1'b0, ERR_NONE};
		if (len != 32'd0 && eob) begin
			t = truncated_token();
		end else if (len != 32'd0) begin
			dec_phase = PH_PAYLOAD;
			dec_pay_left = len;
		end
	endfunction

	// Advances the expected decoder by one byte and gives the token it causes, if any.
	function automatic void decode_byte(input logic [7:0] b, input logic eob,
			output logic fires, output token_t t);
		int n;
		tok_kind_t k;
		logic [63:0] v;
		fires = 1'b1;
		t = '{TK_NIL, 64'd0, 8'd0, 1'b0, ERR_NONE};
		if (dec_discard) begin
			fires = 1'b0;
			if (eob) begin
				dec_discard = 1'b0;
				clear_state();
			end
		end else if (dec_phase == PH_OPER) begin
			dec_acc = {dec_acc[55:0], b};
			dec_opnd_left = dec_opnd_left - 4'd1;
			if (dec_opnd_left != 4'd0) begin
				if (eob) begin
					clear_state();
					t = truncated_token();
				end else begin
					fires = 1'b0;
				end
			end else begin
				v = dec_acc;
				case (dec_prefix)
					PFX_F32: begin
						k = TK_FLOAT;
						v = f32_to_f64(dec_acc[31:0]);
					end
					PFX_F64: k = TK_FLOAT;
					PFX_I8: begin
						k = TK_INT;
						v = {{56{dec_acc[7]}}, dec_acc[7:0]};
					end
					PFX_I16: begin
						k = TK_INT;
						v = {{48{dec_acc[15]}}, dec_acc[15:0]};
					end
					PFX_I32: begin
						k = TK_INT;
						v = {{32{dec_acc[31]}}, dec_acc[31:0]};
					end
					PFX_U8, PFX_U16, PFX_U32, PFX_U64, PFX_I64: k = TK_INT;
					PFX_BIN8, PFX_BIN16, PFX_BIN32: k = TK_BIN;
					PFX_STR8, PFX_STR16, PFX_STR32: k = TK_STR;
					PFX_ARR16, PFX_ARR32: k = TK_ARRAY;
					default: k = TK_MAP;
				endcase
				if (k == TK_STR || k == TK_BIN) begin
					start_string(k, v[31:0], eob, t);
				end else begin
					clear_state();
					t.kind = k;
					t.value = v;
				end
			end
		end else if (dec_phase == PH_PAYLOAD) begin
			dec_pay_left = dec_pay_left - 32'd1;
			if (dec_pay_left != 32'd0 && eob) begin
				clear_state();
				t = truncated_token();
			end else begin
				t.kind = TK_BYTE;
				t.pbyte = b;
				if (dec_pay_left == 32'd0) begin
					clear_state();
					t.plast = 1'b1;
				end
			end
		end else begin
			clear_state();
			n = operand_len(b);
			if (b <= FIXINT_POS_MAX || b >= FIXINT_NEG_MIN) begin
				t.kind = TK_INT;
				t.value = {{56{b[7]}}, b};
			end else if (b <= FIXMAP_MAX) begin
				t.kind = TK_MAP;
				t.value = {56'd0, b & FIXCNT_MASK};
			end else if (b <= FIXARR_MAX) begin
				t.kind = TK_ARRAY;
				t.value = {56'd0, b & FIXCNT_MASK};
			end else if (b <= FIXSTR_MAX) begin
				start_string(TK_STR, {24'd0, b & FIXSTR_MASK}, eob, t);
			end else if (b == PFX_NIL) begin
				t.kind = TK_NIL;
			end else if (b == PFX_FALSE || b == PFX_TRUE) begin
				t.kind = TK_BOOL;
				t.value = {63'd0, b[0]};
			end else if (n == 0) begin
				t.kind = TK_ERROR;
				t.err = ERR_INVALID;
				dec_discard = !eob;
			end else if (eob) begin
				t = truncated_token();
			end else begin
				fires = 1'b0;
				dec_phase = PH_OPER;
				dec_prefix = b;
				dec_opnd_left = 4'(n);
				dec_acc = 64'd0;
			end
		end
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH at %0t: %s got %0h, expected %0h", $realtime, field, got, want);
		mismatches++;
	endtask

	task automatic push_item(input logic [7:0] d, input logic eob);
		feed_item_t it;
		it = '{d, eob, drain_next, fill_idle, fill_stall};
		drain_next = 1'b0;
		feed_q.push_back(it);
	endtask

	// Appends one random value to the frame: a prefix, its operands and any payload.
	task automatic add_value(output int ending);
		logic [7:0] p;
		logic [63:0] opnd;
		int n;
		int len;
		int pick;
		ending = VAL_OPEN;
		len = 0;
		pick = $urandom_range(99);
		if (pick < 5) begin
			p = 8'($urandom_range(255));
		end else if (pick < 8) begin
			p = PFX_RESERVED;
			while (!bad_prefix(p)) begin
				p = PFX_NIL + 8'($urandom_range(31));
			end
		end else if (pick < 35) begin
			p = 8'($urandom_range(255));
			while (p > FIXSTR_MAX && p < FIXINT_NEG_MIN && p != PFX_NIL && p != PFX_FALSE
					&& p != PFX_TRUE) begin
				p = 8'($urandom_range(255));
			end
		end else begin
			p = PFX_NIL;
			while (operand_len(p) == 0) begin
				p = PFX_NIL + 8'($urandom_range(31));
			end
		end
		frame_q.push_back(p);
		n = operand_len(p);
		if (bad_prefix(p)) begin
			ending = VAL_BAD;
		end else if (p > FIXARR_MAX && p <= FIXSTR_MAX) begin
			len = int'(p & FIXSTR_MASK);
		end else if (n != 0) begin
			opnd = {$urandom, $urandom};
			case ($urandom_range(9))
				0: opnd = '0;
				1: opnd = '1;
				default: ;
			endcase
			// Steer single floats towards zero, subnormal, infinity and NaN.
			if (p == PFX_F32) begin
				case ($urandom_range(3))
					0: opnd[30:23] = 8'h00;
					1: opnd[30:23] = 8'hFF;
					default: ;
				endcase
				if ($urandom_range(3) == 0) begin
					opnd[22:0] = '0;
				end
			end
			// Mostly short strings; a long one is cut off by the end mark after a few bytes.
			if (is_string_prefix(p)) begin
				if ($urandom_range(19) != 0) begin
					opnd = 64'($urandom_range(8));
				end
				opnd = opnd & ((64'd1 << (8 * n)) - 64'd1);
				if (opnd > LONG_STRING) begin
					len = 3;
					ending = VAL_LONG;
				end else begin
					len = int'(opnd);
				end
			end
			for (int i = n - 1; i >= 0; i--) begin
				frame_q.push_back(opnd[8 * i +: 8]);
			end
		end
		repeat (len) frame_q.push_back(8'($urandom_range(255)));
	endtask

	// One buffer of values, sometimes cut short, followed by noise after a bad prefix.
	task automatic add_buffer();
		int ending;
		int counted;
		int cut;
		logic eob_last;
		frame_q.delete();
		ending = VAL_OPEN;
		eob_last = 1'b1;
		repeat ($urandom_range(1, 6)) begin
			if (ending == VAL_OPEN) begin
				add_value(ending);
			end
		end
		counted = frame_q.size();
		if (ending == VAL_BAD) begin
			repeat ($urandom_range(3)) frame_q.push_back(8'($urandom_range(255)));
		end else if (ending == VAL_OPEN) begin
			if ($urandom_range(5) == 0) begin
				cut = $urandom_range(frame_q.size() - 1);
				while (frame_q.size() > cut + 1) begin
					void'(frame_q.pop_back());
				end
				counted = frame_q.size();
			end else if ($urandom_range(9) == 0) begin
				eob_last = 1'b0;
			end
		end
		foreach (frame_q[i]) begin
			push_item(frame_q[i], eob_last && (i == frame_q.size() - 1));
		end
		rand_count += counted;
	endtask

	// Byte driver and token stall, both changing on the falling edge.
	always @(negedge clk) begin
		feed_item_t it;
		logic held;
		if (!arst_n) begin
			byte_valid <= 1'b0;
			token_stall <= 1'b0;
		end else begin
			token_stall <= ($urandom_range(99) < stall_pct);
			if (!byte_valid || byte_taken) begin
				held = 1'b1;
				if (feed_q.size() != 0) begin
					held = (feed_q[0].drain && tokens_due.size() != 0)
						|| ($urandom_range(99) < feed_q[0].idle_pct);
				end
				if (!held) begin
					it = feed_q.pop_front();
					byte_valid <= 1'b1;
					data_byte <= it.data;
					end_of_buffer <= it.eob;
					stall_pct <= it.stall_pct;
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// Prediction on each byte beat, checking on each token beat, and the watchdog.
	always @(posedge clk) begin
		token_t fresh;
		token_t due;
		logic fires;
		logic byte_beat;
		logic token_beat;
		byte_beat = arst_n && byte_valid && !byte_stall;
		token_beat = arst_n && token_valid && !token_stall;
		byte_taken <= byte_beat;
		if (byte_beat) begin
			decode_byte(data_byte, end_of_buffer, fires, fresh);
			if (fires) begin
				tokens_due.push_back(fresh);
			end
		end
		if (token_beat) begin
			if (tokens_due.size() == 0) begin
				report_mismatch("token with none due, token_kind", 64'(token_kind), 64'd0);
			end else begin
				due = tokens_due.pop_front();
				if (token_kind !== due.kind) begin
					report_mismatch("token_kind", 64'(token_kind), 64'(due.kind));
				end
				if (token_value !== due.value) begin
					report_mismatch("token_value", token_value, due.value);
				end
				if (payload_byte !== due.pbyte) begin
					report_mismatch("payload_byte", 64'(payload_byte), 64'(due.pbyte));
				end
				if (payload_last !== due.plast) begin
					report_mismatch("payload_last", 64'(payload_last), 64'(due.plast));
				end
				if (error_code !== due.err) begin
					report_mismatch("error_code", 64'(error_code), 64'(due.err));
				end
			end
		end
		if (arst_n) begin
			if (byte_beat || token_beat) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == QUIET_LIMIT) begin
				$display("FAIL msgpack_stream_tokenizer_core");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		logic mid_drain_done;
		mid_drain_done = 1'b0;

		// Directed bytes: fixed formats at their limits, end marks and the error paths.
		push_item(PFX_NIL, 1'b1);
		push_item(PFX_FALSE, 1'b0);
		push_item(PFX_TRUE, 1'b0);
		push_item(FIXINT_POS_MAX, 1'b0);
		push_item(FIXINT_NEG_MIN, 1'b0);
		push_item(FIXMAP_MAX, 1'b0);
		push_item(FIXARR_MAX, 1'b0);
		push_item(FIXARR_MAX + 8'd1, 1'b1);
		push_item(FIXARR_MAX + 8'd2, 1'b0);
		push_item(8'h41, 1'b0);
		push_item(PFX_RESERVED, 1'b0);
		push_item(8'h55, 1'b0);
		push_item(8'h33, 1'b1);
		push_item(PFX_RESERVED, 1'b1);
		push_item(PFX_I8, 1'b0);
		push_item(8'h80, 1'b0);
		push_item(PFX_F32, 1'b0);
		push_item(8'h00, 1'b0);
		push_item(8'h00, 1'b0);
		push_item(8'h00, 1'b0);
		push_item(8'h01, 1'b0);
		push_item(PFX_STR8, 1'b1);
		push_item(FIXARR_MAX + 8'd4, 1'b0);
		push_item(8'h41, 1'b0);
		push_item(8'h42, 1'b1);
		push_item(PFX_BIN8, 1'b0);
		push_item(8'h05, 1'b1);

		// Random buffers, cycling through the idle and stall mixes.
		drain_next = 1'b1;
		while (rand_count < RANDOM_ITEMS) begin
			if (rand_count >= RANDOM_ITEMS / 2 && !mid_drain_done) begin
				drain_next = 1'b1;
				mid_drain_done = 1'b1;
			end
			case ((rand_count / 150) % 5)
				1: begin
					fill_idle = 82;
					fill_stall = 0;
				end
				2: begin
					fill_idle = 0;
					fill_stall = 82;
				end
				3: begin
					fill_idle = 19;
					fill_stall = 19;
				end
				default: begin
					fill_idle = 0;
					fill_stall = 0;
				end
			endcase
			add_buffer();
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (feed_q.size() != 0 || byte_valid || tokens_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS msgpack_stream_tokenizer_core");
		end else begin
			$display("FAIL msgpack_stream_tokenizer_core");
		end
		$finish;
	end

endmodule
